/* rtl/anm_rsd_pkg.sv */
`default_nettype none
package anm_rsd_pkg;

   // Default frame buffer size in bytes
   localparam int FRAME_BYTES_DEFAULT = 65536;

   // Opcode byte fields
   localparam logic [7:0] OPC_SKIP_FLAG  = 8'h80;
   localparam logic [7:0] OPC_COUNT_MASK = 8'h7F;
   localparam logic [7:0] OPC_SHORT_RLE  = 8'h00;

   // Long word fields
   localparam logic [15:0] LONG_OP_FLAG  = 16'h8000;
   localparam logic [15:0] LONG_RLE_FLAG = 16'h4000;
   localparam logic [15:0] LONG_CNT_MASK = 16'h3FFF;
   localparam logic [15:0] LONG_STOP     = 16'h0000;

   localparam int CNT_W = 15;

   typedef enum logic [3:0] {
      PH_STOPPED  = 4'd0,
      PH_OPCODE   = 4'd1,
      PH_SRLE_CNT = 4'd2,
      PH_SRLE_COL = 4'd3,
      PH_COPY     = 4'd4,
      PH_LONG_LO  = 4'd5,
      PH_LONG_HI  = 4'd6,
      PH_LRLE_COL = 4'd7
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [15:0] write_address;
      logic [7:0]  write_value;
      logic [13:0] run_length;
      logic        frame_done;
      logic        overflow;
   } rsp_type;

   // Parser state other than the destination offset
   typedef struct packed {
      phase_type          phase;
      logic [CNT_W-1:0]   count;
      logic [7:0]         held_low;
   } parse_type;

endpackage
`default_nettype wire

/* rtl/anm_rsd_decode.sv */
`default_nettype none
module anm_rsd_decode #(
   parameter int FRAME_BYTES = anm_rsd_pkg::FRAME_BYTES_DEFAULT,
   parameter int OFF_W       = 17
) (
   input  wire anm_rsd_pkg::req_type   item,
   input  wire anm_rsd_pkg::parse_type parse_cur,
   input  wire logic [OFF_W-1:0]       offset_cur,
   output anm_rsd_pkg::parse_type      parse_nxt,
   output logic [OFF_W-1:0]            offset_nxt,
   output logic                        result_valid,
   output anm_rsd_pkg::rsp_type        result
);
   import anm_rsd_pkg::*;

   localparam int SUM_W = ((OFF_W > CNT_W) ? OFF_W : CNT_W) + 1;
   localparam logic [SUM_W-1:0] FRAME_SUM = SUM_W'(FRAME_BYTES);
   localparam logic [OFF_W-1:0] FRAME_OFF = OFF_W'(FRAME_BYTES);

   parse_type        ps;
   logic [OFF_W-1:0] off;
   logic [7:0]       b;
   logic [15:0]      word;
   logic             adv_en;
   logic [CNT_W-1:0] adv_n;
   logic             emit_en;
   logic [SUM_W-1:0] sum;
   logic [OFF_W-1:0] avail;
   logic             stop;

   always_comb begin
      b    = item.data_byte;
      ps   = parse_cur;
      off  = offset_cur;
      // frame start restarts the parser before the byte is decoded
      if (item.frame_start) begin
         ps.phase    = PH_OPCODE;
         ps.count    = '0;
         ps.held_low = '0;
         off         = '0;
      end
      word      = {b, ps.held_low};
      parse_nxt = ps;
      adv_en    = 1'b0;
      adv_n     = '0;
      emit_en   = 1'b0;
      stop      = 1'b0;

      case (ps.phase)
         PH_OPCODE: begin
            if (b == OPC_SHORT_RLE) begin
               parse_nxt.phase = PH_SRLE_CNT;
            end else if ((b & OPC_SKIP_FLAG) == 8'h00) begin
               parse_nxt.count = CNT_W'(b);
               parse_nxt.phase = PH_COPY;
            end else if ((b & OPC_COUNT_MASK) != 8'h00) begin
               adv_en = 1'b1;
               adv_n  = CNT_W'(b & OPC_COUNT_MASK);
            end else begin
               parse_nxt.phase = PH_LONG_LO;
            end
         end
         PH_SRLE_CNT: begin
            parse_nxt.count = CNT_W'(b);
            parse_nxt.phase = PH_SRLE_COL;
         end
         PH_SRLE_COL, PH_LRLE_COL: begin
            parse_nxt.phase = PH_OPCODE;
            if (ps.count != '0) begin
               emit_en = 1'b1;
               adv_en  = 1'b1;
               adv_n   = ps.count;
            end
         end
         PH_COPY: begin
            parse_nxt.count = ps.count - CNT_W'(1);
            if (parse_nxt.count == '0) begin
               parse_nxt.phase = PH_OPCODE;
            end
            emit_en = 1'b1;
            adv_en  = 1'b1;
            adv_n   = CNT_W'(1);
         end
         PH_LONG_LO: begin
            parse_nxt.held_low = b;
            parse_nxt.phase    = PH_LONG_HI;
         end
         PH_LONG_HI: begin
            parse_nxt.phase = PH_OPCODE;
            if (word == LONG_STOP) begin
               parse_nxt.phase = PH_STOPPED;
               stop            = 1'b1;
            end else if ((word & LONG_OP_FLAG) == 16'h0000) begin
               adv_en = 1'b1;
               adv_n  = CNT_W'(word);
            end else begin
               parse_nxt.count = CNT_W'(word & LONG_CNT_MASK);
               if ((word & LONG_RLE_FLAG) == 16'h0000) begin
                  if ((word & LONG_CNT_MASK) != 16'h0000) begin
                     parse_nxt.phase = PH_COPY;
                  end
               end else begin
                  parse_nxt.phase = PH_LRLE_COL;
               end
            end
         end
         default: begin
            parse_nxt.phase = PH_STOPPED;
         end
      endcase

      // one saturating adder serves skips and writes
      sum = SUM_W'(off) + SUM_W'(adv_n);
      if (!adv_en) begin
         offset_nxt = off;
      end else if (sum > FRAME_SUM) begin
         offset_nxt = FRAME_OFF;
      end else begin
         offset_nxt = OFF_W'(sum);
      end

      // clip the write at the frame end
      avail        = FRAME_OFF - off;
      result       = '0;
      result_valid = emit_en | stop;
      result.frame_done = stop;
      if (emit_en) begin
         result.write_value = b;
         if (off >= FRAME_OFF) begin
            result.overflow = 1'b1;
         end else begin
            result.write_address = 16'(off);
            if (SUM_W'(adv_n) > SUM_W'(avail)) begin
               result.run_length = 14'(avail);
               result.overflow   = 1'b1;
            end else begin
               result.run_length = 14'(adv_n);
            end
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/anm_run_skip_dump_decoder_core.sv */
`default_nettype none
// Run/skip/dump delta-frame decoder. Feed the compressed frame record one
// byte per transaction on req_, raising frame_start with its first byte; this
// restarts the parser and sets the destination offset to zero. Each byte
// produces zero or one rsp_ transaction: copy bytes come out as single-pixel
// writes (run_length 1), a fill comes out as one run descriptor (address,
// color, length), skips only move the offset, and the stop word gives a
// transaction with frame_done set, after which bytes are dropped until the
// next frame_start. Writes that reach past FRAME_BYTES are clipped and carry
// overflow; a write starting at or beyond the frame end has address 0 and
// length 0. The block takes one byte per cycle while not stalled; each byte is
// held in the input register, then the decode of that byte against the parser
// state lands in the result register. A held rsp_stall stalls the result
// register and, once the input register is full, backs up into req_stall.
module anm_run_skip_dump_decoder_core #(
   parameter int FRAME_BYTES = anm_rsd_pkg::FRAME_BYTES_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire anm_rsd_pkg::req_type req_item,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output anm_rsd_pkg::rsp_type      rsp_item
);
   import anm_rsd_pkg::*;

   // offset runs 0..FRAME_BYTES inclusive
   localparam int OFF_W = $clog2(FRAME_BYTES + 1);

   logic             in_valid_ff, in_valid_in;
   req_type          in_item_ff, in_item_in;
   parse_type        parse_ff, parse_in;
   logic [OFF_W-1:0] offset_ff, offset_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   parse_type        dec_parse;
   logic [OFF_W-1:0] dec_offset;
   logic             dec_valid;
   rsp_type          dec_result;
   logic             step;
   logic             req_take;

   anm_rsd_decode #(
      .FRAME_BYTES(FRAME_BYTES),
      .OFF_W      (OFF_W)
   ) u_decode (
      .item        (in_item_ff),
      .parse_cur   (parse_ff),
      .offset_cur  (offset_ff),
      .parse_nxt   (dec_parse),
      .offset_nxt  (dec_offset),
      .result_valid(dec_valid),
      .result      (dec_result)
   );

   // decode the held byte whenever the result register is free or draining
   always_comb begin
      step         = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall    = in_valid_ff && !step;
      req_take     = req_valid && !req_stall;

      in_valid_in  = req_take ? 1'b1 : (in_valid_ff && !step);
      in_item_in   = req_take ? req_item : in_item_ff;

      parse_in     = step ? dec_parse  : parse_ff;
      offset_in    = step ? dec_offset : offset_ff;

      // hold a stalled result; otherwise load the new one (or drop valid)
      if (step) begin
         rsp_valid_in = dec_valid;
         rsp_in       = dec_result;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_in       = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         parse_ff     <= '{phase: PH_STOPPED, count: '0, held_low: '0};
         offset_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         parse_ff     <= parse_in;
         offset_ff    <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire
